// ===== rtl/dtam_pkg.sv =====
package dtam_pkg;

  localparam int NumKinds = 4;
  localparam int KindW    = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [KindW-1:0] KIND_VOLT  = 2'd0;
  localparam logic [KindW-1:0] KIND_TEMP  = 2'd1;
  localparam logic [KindW-1:0] KIND_FAULT = 2'd2;
  localparam logic [KindW-1:0] KIND_LINK  = 2'd3;

  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic OP_FULL = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_VOLT_CRIT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_VOLT_WARN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_CRIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_WARN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NOTIFY    = 3'd5;

  localparam logic [7:0] CntMax = 8'd255;

  typedef struct packed {
    logic [15:0]        volt_crit_level;
    logic [15:0]        volt_warn_level;
    logic signed [11:0] temp_crit_level;
    logic signed [11:0] temp_warn_level;
    logic [7:0]         debounce_limit;
    logic               notify_enable;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [15:0]        volt_mv;
    logic signed [11:0] temp_tenths;
    logic               temp_valid;
    logic [15:0]        fault_code;
    logic               link_good;
  } item_t;

  typedef struct packed {
    logic action;
    logic severity;
    logic notify;
  } slot_t;

  typedef struct packed {
    logic [NumKinds-1:0]  mask;
    slot_t [NumKinds-1:0] slots;
  } batch_t;

  typedef struct packed {
    logic [KindW-1:0] alarm_kind;
    logic             action;
    logic             severity;
    logic             notify;
    logic             last;
  } event_t;

endpackage

// ===== rtl/debounced_threshold_alarm_monitor_core.sv =====
// Alarm monitor with four debounced up/down counters (low voltage, high
// temperature, controller fault, link loss). A request enters an input
// register, is evaluated against the thresholds and its events
// (zero to four, in the order voltage, temperature, fault, link) land in an
// event register that drains one event per cycle on the output channel while
// out_ready is high, with last marking the final event of a request. A new
// request is taken every cycle while the event register can accept the next
// batch; the single output port sets the pace, so a request that raises several
// events holds off the next batch until its last event is accepted.
module debounced_threshold_alarm_monitor_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dtam_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dtam_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [15:0]                   volt_mv,
  input  logic signed [11:0]            temp_tenths,
  input  logic                          temp_valid,
  input  logic [15:0]                   fault_code,
  input  logic                          link_good,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtam_pkg::KindW-1:0]    alarm_kind,
  output logic                          action,
  output logic                          severity,
  output logic                          notify,
  output logic                          last
);
  import dtam_pkg::*;

  cfg_t   cfg;
  item_t  in_item;
  batch_t batch;
  logic   batch_valid;
  logic   take;
  event_t ev;

  assign in_item.operation   = operation;
  assign in_item.volt_mv     = volt_mv;
  assign in_item.temp_tenths = temp_tenths;
  assign in_item.temp_valid  = temp_valid;
  assign in_item.fault_code  = fault_code;
  assign in_item.link_good   = link_good;

  dtam_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dtam_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .cfg         (cfg),
    .take        (take),
    .batch_valid (batch_valid),
    .batch       (batch)
  );

  dtam_evq u_evq (
    .clk         (clk),
    .rst         (rst),
    .batch_valid (batch_valid),
    .batch       (batch),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ev          (ev)
  );

  assign alarm_kind = ev.alarm_kind;
  assign action     = ev.action;
  assign severity   = ev.severity;
  assign notify     = ev.notify;
  assign last       = ev.last;

endmodule

// ===== rtl/dtam_cfg.sv =====
module dtam_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dtam_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dtam_pkg::CfgDataW-1:0]  cfg_data,
  output dtam_pkg::cfg_t                 cfg
);
  import dtam_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_crit_level <= 16'd0;
      cfg.volt_warn_level <= 16'd0;
      cfg.temp_crit_level <= 12'sd2000;
      cfg.temp_warn_level <= 12'sd2000;
      cfg.debounce_limit  <= 8'd3;
      cfg.notify_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOLT_CRIT: cfg.volt_crit_level <= cfg_data;
        CFG_VOLT_WARN: cfg.volt_warn_level <= cfg_data;
        CFG_TEMP_CRIT: cfg.temp_crit_level <= cfg_data[11:0];
        CFG_TEMP_WARN: cfg.temp_warn_level <= cfg_data[11:0];
        CFG_DEBOUNCE:  cfg.debounce_limit  <= cfg_data[7:0];
        CFG_NOTIFY:    cfg.notify_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dtam_eval.sv =====
module dtam_eval (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dtam_pkg::item_t in_item,
  input  dtam_pkg::cfg_t  cfg,
  input  logic            take,
  output logic            batch_valid,
  output dtam_pkg::batch_t batch
);
  import dtam_pkg::*;

  typedef struct packed {
    logic [7:0] cnt;
    logic       set_ev;
    logic       clr_ev;
  } step_t;

  function automatic step_t cnt_step(logic [7:0] cnt, logic up, logic down,
                                     logic [7:0] limit);
    step_t s;
    s.cnt    = cnt;
    s.set_ev = 1'b0;
    s.clr_ev = 1'b0;
    if (up) begin
      if (cnt != CntMax) s.cnt = cnt + 8'd1;
      s.set_ev = (s.cnt >= limit);
    end else if (down && cnt != 8'd0) begin
      s.cnt    = cnt - 8'd1;
      s.clr_ev = (s.cnt == 8'd0);
    end
    return s;
  endfunction

  item_t      item;
  logic       item_valid;
  logic [7:0] volt_counter;
  logic [7:0] temp_counter;
  logic [7:0] fault_counter;
  logic [7:0] link_counter;

  logic  full;
  logic  volt_crit, volt_bad, temp_crit, temp_bad, fault_bad;
  logic  link_reset;
  step_t volt_s, temp_s, fault_s, link_s;
  logic  link_clr;
  logic  [NumKinds-1:0] crit;
  step_t [NumKinds-1:0] st;

  assign in_ready    = !item_valid || take;
  assign batch_valid = item_valid;

  always_comb begin
    full       = (item.operation == OP_FULL);
    volt_crit  = item.volt_mv < cfg.volt_crit_level;
    volt_bad   = volt_crit || (item.volt_mv < cfg.volt_warn_level);
    temp_crit  = item.temp_tenths > cfg.temp_crit_level;
    temp_bad   = temp_crit || (item.temp_tenths > cfg.temp_warn_level);
    fault_bad  = (item.fault_code != 16'd0);
    link_reset = full && item.link_good;

    volt_s  = cnt_step(volt_counter, full && item.volt_mv != 16'd0 && volt_bad,
                       full && item.volt_mv != 16'd0 && !volt_bad, cfg.debounce_limit);
    temp_s  = cnt_step(temp_counter, full && item.temp_valid && temp_bad,
                       full && item.temp_valid && !temp_bad, cfg.debounce_limit);
    fault_s = cnt_step(fault_counter, full && fault_bad, full && !fault_bad,
                       cfg.debounce_limit);
    link_s  = cnt_step(link_counter, !full && !item.link_good,
                       !full && item.link_good, cfg.debounce_limit);
    link_clr = link_s.clr_ev || link_reset;

    st   = {link_s, fault_s, temp_s, volt_s};
    crit = {1'b1, 1'b1, temp_crit, volt_crit};

    for (int i = 0; i < NumKinds; i++) begin
      batch.mask[i] = st[i].set_ev || st[i].clr_ev;
      if (st[i].set_ev) begin
        batch.slots[i].action   = ACT_SET;
        batch.slots[i].severity = crit[i];
        batch.slots[i].notify   = crit[i] && cfg.notify_enable;
      end else begin
        batch.slots[i].action   = ACT_CLEAR;
        batch.slots[i].severity = 1'b0;
        batch.slots[i].notify   = 1'b0;
      end
    end
    // link good in a full sample always reports a clear
    batch.mask[3] = link_s.set_ev || link_clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      volt_counter  <= 8'd0;
      temp_counter  <= 8'd0;
      fault_counter <= 8'd0;
      link_counter  <= 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        item_valid <= 1'b1;
      end else if (take) begin
        item_valid <= 1'b0;
      end
      if (item_valid && take) begin
        volt_counter  <= volt_s.cnt;
        temp_counter  <= temp_s.cnt;
        fault_counter <= fault_s.cnt;
        link_counter  <= link_reset ? 8'd0 : link_s.cnt;
      end
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/dtam_evq.sv =====
module dtam_evq (
  input  logic             clk,
  input  logic             rst,
  input  logic             batch_valid,
  input  dtam_pkg::batch_t batch,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output dtam_pkg::event_t ev
);
  import dtam_pkg::*;

  logic [NumKinds-1:0]  mask;
  slot_t [NumKinds-1:0] slots;
  logic [KindW-1:0]     sel;
  logic [NumKinds-1:0]  rest;
  logic                 out_fire;

  always_comb begin
    sel = KIND_VOLT;
    for (int i = NumKinds - 1; i >= 0; i--) begin
      if (mask[i]) sel = KindW'(i);
    end
    rest     = mask & ~(NumKinds'(1) << sel);
    out_valid = |mask;
    out_fire = out_valid && out_ready;
    take     = (mask == '0) || (out_fire && rest == '0);

    ev.alarm_kind = sel;
    ev.action     = slots[sel].action;
    ev.severity   = slots[sel].severity;
    ev.notify     = slots[sel].notify;
    ev.last       = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (take) begin
      mask <= batch_valid ? batch.mask : '0;
    end else if (out_fire) begin
      mask <= rest;
    end
    if (take && batch_valid) begin
      slots <= batch.slots;
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import dtam_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 8;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                operation   = 1'b0;
  logic [15:0]         volt_mv     = '0;
  logic signed [11:0]  temp_tenths = '0;
  logic                temp_valid  = 1'b0;
  logic [15:0]         fault_code  = '0;
  logic                link_good   = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [KindW-1:0]    alarm_kind;
  logic                action;
  logic                severity;
  logic                notify;
  logic                last;

  debounced_threshold_alarm_monitor_core dut (.*);

  initial forever #5 clk = ~clk;

  cfg_t          cfg_shadow;
  logic [7:0]    alarm_cnt [NumKinds];
  item_t         requests_pending [$];
  event_t        events_due [$];
  event_t        batch [$];
  int            requests_queued = 0;
  int            requests_taken  = 0;
  int            events_seen     = 0;
  int            mismatches      = 0;
  logic [NumKinds-1:0] trend_bad = '0;

  // alarm predictor

  task automatic raise_alarm(input logic [KindW-1:0] kind, input logic crit);
    event_t ev;
    if (alarm_cnt[kind] != CntMax) alarm_cnt[kind] = alarm_cnt[kind] + 8'd1;
    if (alarm_cnt[kind] >= cfg_shadow.debounce_limit) begin
      ev.alarm_kind = kind;
      ev.action     = ACT_SET;
      ev.severity   = crit;
      ev.notify     = crit & cfg_shadow.notify_enable;
      ev.last       = 1'b0;
      batch.push_back(ev);
    end
  endtask

  task automatic lower_alarm(input logic [KindW-1:0] kind);
    event_t ev;
    if (alarm_cnt[kind] != 8'd0) begin
      alarm_cnt[kind] = alarm_cnt[kind] - 8'd1;
      if (alarm_cnt[kind] == 8'd0) begin
        ev.alarm_kind = kind;
        ev.action     = ACT_CLEAR;
        ev.severity   = 1'b0;
        ev.notify     = 1'b0;
        ev.last       = 1'b0;
        batch.push_back(ev);
      end
    end
  endtask

  task automatic predict_alarms(input item_t it);
    event_t ev;
    batch.delete();
    if (it.operation == OP_FULL) begin
      if (it.volt_mv != 16'd0) begin
        if (it.volt_mv < cfg_shadow.volt_crit_level) raise_alarm(KIND_VOLT, 1'b1);
        else if (it.volt_mv < cfg_shadow.volt_warn_level) raise_alarm(KIND_VOLT, 1'b0);
        else lower_alarm(KIND_VOLT);
      end
      if (it.temp_valid) begin
        if ($signed(it.temp_tenths) > $signed(cfg_shadow.temp_crit_level))
          raise_alarm(KIND_TEMP, 1'b1);
        else if ($signed(it.temp_tenths) > $signed(cfg_shadow.temp_warn_level))
          raise_alarm(KIND_TEMP, 1'b0);
        else
          lower_alarm(KIND_TEMP);
      end
      if (it.fault_code != 16'd0) raise_alarm(KIND_FAULT, 1'b1);
      else lower_alarm(KIND_FAULT);
      if (it.link_good) begin
        alarm_cnt[KIND_LINK] = 8'd0;
        ev.alarm_kind = KIND_LINK;
        ev.action     = ACT_CLEAR;
        ev.severity   = 1'b0;
        ev.notify     = 1'b0;
        ev.last       = 1'b0;
        batch.push_back(ev);
      end
    end else if (!it.link_good) begin
      raise_alarm(KIND_LINK, 1'b1);
    end else begin
      lower_alarm(KIND_LINK);
    end
    if (batch.size() > 0) begin
      ev = batch.pop_back();
      ev.last = 1'b1;
      batch.push_back(ev);
    end
    foreach (batch[i]) events_due.push_back(batch[i]);
  endtask

  // configuration and stimulus

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    case (idx)
      CFG_VOLT_CRIT: cfg_shadow.volt_crit_level = value[15:0];
      CFG_VOLT_WARN: cfg_shadow.volt_warn_level = value[15:0];
      CFG_TEMP_CRIT: cfg_shadow.temp_crit_level = value[11:0];
      CFG_TEMP_WARN: cfg_shadow.temp_warn_level = value[11:0];
      CFG_DEBOUNCE:  cfg_shadow.debounce_limit  = value[7:0];
      CFG_NOTIFY:    cfg_shadow.notify_enable   = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input int vc, input int vw, input int tc, input int tw,
                              input int db, input int ne);
    write_reg(CFG_VOLT_CRIT, vc);
    write_reg(CFG_VOLT_WARN, vw);
    write_reg(CFG_TEMP_CRIT, tc);
    write_reg(CFG_TEMP_WARN, tw);
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_NOTIFY, ne);
  endtask

  task automatic wait_idle();
    while (requests_taken != requests_queued || events_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic queue_request(input logic op, input int volt, input int temp,
                               input logic tv, input int fault, input logic link);
    item_t it;
    it.operation   = op;
    it.volt_mv     = volt[15:0];
    it.temp_tenths = temp[11:0];
    it.temp_valid  = tv;
    it.fault_code  = fault[15:0];
    it.link_good   = link;
    requests_pending.push_back(it);
    requests_queued++;
  endtask

  task automatic queue_random_request();
    logic op, tv, link;
    int   volt, temp, fault, bad_volt, hot_temp;
    for (int k = 0; k < NumKinds; k++)
      if ($urandom_range(0, 7) == 0) trend_bad[k] = ~trend_bad[k];
    op = ($urandom_range(0, 3) == 0) ? OP_POLL : OP_FULL;
    bad_volt = (cfg_shadow.volt_crit_level > cfg_shadow.volt_warn_level) ?
               cfg_shadow.volt_crit_level : cfg_shadow.volt_warn_level;
    hot_temp = ($signed(cfg_shadow.temp_crit_level) < $signed(cfg_shadow.temp_warn_level)) ?
               $signed(cfg_shadow.temp_crit_level) : $signed(cfg_shadow.temp_warn_level);
    if ($urandom_range(0, 9) == 0) volt = 0;
    else if ($urandom_range(0, 9) == 0) volt = $urandom_range(1, 65535);
    else if (trend_bad[KIND_VOLT] && bad_volt > 1) volt = $urandom_range(1, bad_volt - 1);
    else volt = $urandom_range((bad_volt > 0) ? bad_volt : 1, 65535);
    if ($urandom_range(0, 9) == 0) temp = -1000 + $urandom_range(0, 3000);
    else if (trend_bad[KIND_TEMP] && hot_temp < 2000)
      temp = hot_temp + 1 + $urandom_range(0, 1999 - hot_temp);
    else temp = -1000 + $urandom_range(0, hot_temp + 1000);
    tv = ($urandom_range(0, 7) != 0);
    if (!trend_bad[KIND_FAULT]) fault = 0;
    else if ($urandom_range(0, 3) == 0) fault = 16'hFFFF;
    else fault = $urandom_range(1, 65535);
    if (op == OP_POLL) link = !trend_bad[KIND_LINK];
    else if (trend_bad[KIND_LINK]) link = ($urandom_range(0, 5) == 0);
    else link = 1'($urandom_range(0, 1));
    // noise
    if ($urandom_range(0, 9) == 0) begin
      op    = 1'($urandom_range(0, 1));
      volt  = $urandom_range(0, 65535);
      temp  = -1000 + $urandom_range(0, 3000);
      tv    = 1'($urandom_range(0, 1));
      fault = $urandom_range(0, 65535);
      link  = 1'($urandom_range(0, 1));
    end
    queue_request(op, volt, temp, tv, fault, link);
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // request driver

  item_t offer;
  int    burst_left = 4;
  int    gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 4;
      gap_left   = 0;
      foreach (alarm_cnt[k]) alarm_cnt[k] = 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        offer = requests_pending.pop_front();
        predict_alarms(offer);
        requests_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_pending.size() > 0) begin
        offer = requests_pending[0];
        in_valid    <= 1'b1;
        operation   <= offer.operation;
        volt_mv     <= offer.volt_mv;
        temp_tenths <= offer.temp_tenths;
        temp_valid  <= offer.temp_valid;
        fault_code  <= offer.fault_code;
        link_good   <= offer.link_good;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // event monitor and receiver stalls

  event_t got, want;
  int     rx_cycle  = 0;
  int     hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_cycle  = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        events_seen++;
        got.alarm_kind = alarm_kind;
        got.action     = action;
        got.severity   = severity;
        got.notify     = notify;
        got.last       = last;
        if (events_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected event kind=%0d act=%0d sev=%0d ntf=%0d last=%0d",
                                  got.alarm_kind, got.action, got.severity, got.notify,
                                  got.last));
        end else begin
          want = events_due.pop_front();
          if (got.alarm_kind !== want.alarm_kind || got.action !== want.action ||
              got.severity !== want.severity || got.notify !== want.notify ||
              got.last !== want.last)
            flag_mismatch($sformatf(
              "expected kind=%0d act=%0d sev=%0d ntf=%0d last=%0d, got %0d %0d %0d %0d %0d",
              want.alarm_kind, want.action, want.severity, want.notify, want.last,
              got.alarm_kind, got.action, got.severity, got.notify, got.last));
        end
        if (events_seen == 30 || events_seen == 60) hold_left = 120;
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((rx_cycle % 5) != 0);
        endcase
      end
    end
  end

  // watchdog

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_shadow.volt_crit_level = 16'd0;
    cfg_shadow.volt_warn_level = 16'd0;
    cfg_shadow.temp_crit_level = 12'sd2000;
    cfg_shadow.temp_warn_level = 12'sd2000;
    cfg_shadow.debounce_limit  = 8'd3;
    cfg_shadow.notify_enable   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds
    queue_request(OP_FULL, 65535, 2000, 1'b1, 16'hFFFF, 1'b1);
    queue_request(OP_FULL, 1, -1000, 1'b1, 0, 1'b0);
    wait_idle();

    // directed requests
    apply_config(3000, 3600, 600, 450, 2, 1);
    queue_request(OP_FULL, 0, 0, 1'b0, 0, 1'b0);
    queue_request(OP_FULL, 1, 2000, 1'b1, 16'hFFFF, 1'b0);
    queue_request(OP_FULL, 1, 2000, 1'b1, 16'hFFFF, 1'b0);
    queue_request(OP_FULL, 3500, 500, 1'b1, 1, 1'b1);
    queue_request(OP_FULL, 3000, 600, 1'b1, 16'h8000, 1'b0);
    for (int i = 0; i < 5; i++) queue_request(OP_FULL, 65535, -1000, 1'b1, 0, 1'b0);
    queue_request(OP_FULL, 3600, 450, 1'b1, 0, 1'b0);
    queue_request(OP_POLL, 1, 2000, 1'b1, 16'hFFFF, 1'b0);
    queue_request(OP_POLL, 0, 0, 1'b0, 0, 1'b0);
    queue_request(OP_POLL, 65535, -1000, 1'b1, 0, 1'b0);
    queue_request(OP_POLL, 0, 0, 1'b0, 16'hFFFF, 1'b1);
    queue_request(OP_POLL, 0, 0, 1'b0, 0, 1'b1);
    queue_request(OP_POLL, 0, 0, 1'b0, 0, 1'b1);
    queue_request(OP_POLL, 0, 0, 1'b0, 0, 1'b1);
    queue_request(OP_FULL, 2999, 601, 1'b1, 16'hFFFF, 1'b1);
    queue_request(OP_FULL, 0, 2000, 1'b0, 0, 1'b1);
    wait_idle();

    // random phases over several threshold settings
    apply_config(3300, 3600, 650, 500, 3, 1);
    repeat (16) queue_random_request();
    wait_idle();
    apply_config(65535, 65535, -1000, -1000, 1, 0);
    repeat (16) queue_random_request();
    wait_idle();
    apply_config(0, 65535, 2000, -1000, 0, 1);
    repeat (16) queue_random_request();
    wait_idle();

    // link counter saturation, then a full sample with link good clears it
    apply_config(0, 0, 2000, 2000, 255, 1);
    repeat (258)
      queue_request(OP_POLL, $urandom_range(0, 65535), -1000 + $urandom_range(0, 3000),
                    1'($urandom_range(0, 1)), $urandom_range(0, 65535), 1'b0);
    repeat (2)
      queue_request(OP_POLL, $urandom_range(0, 65535), -1000 + $urandom_range(0, 3000),
                    1'($urandom_range(0, 1)), $urandom_range(0, 65535), 1'b1);
    queue_request(OP_FULL, 0, 0, 1'b0, 0, 1'b1);
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dtam_pkg.sv
rtl/dtam_cfg.sv
rtl/dtam_eval.sv
rtl/dtam_evq.sv
rtl/debounced_threshold_alarm_monitor_core.sv
sim/tb.sv
